FILE: design/psd_pkg.sv
package psd_pkg;

    // Parser phases
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_START      = 4'd1;
    localparam logic [3:0] PH_RESYNC     = 4'd2;
    localparam logic [3:0] PH_PESNEXT    = 4'd3;
    localparam logic [3:0] PH_PACK_FIX   = 4'd4;
    localparam logic [3:0] PH_PACK_STUFF = 4'd5;
    localparam logic [3:0] PH_PACK_NEXT  = 4'd6;
    localparam logic [3:0] PH_SYS_LEN    = 4'd7;
    localparam logic [3:0] PH_SYS_SKIP   = 4'd8;
    localparam logic [3:0] PH_MAP_CODE   = 4'd9;
    localparam logic [3:0] PH_MAP_LEN    = 4'd10;
    localparam logic [3:0] PH_MAP_SKIP   = 4'd11;
    localparam logic [3:0] PH_PES_HDR    = 4'd12;
    localparam logic [3:0] PH_PES_EXT    = 4'd13;
    localparam logic [3:0] PH_BODY       = 4'd14;
    localparam logic [3:0] PH_CONT       = 4'd15;

    // Stream ids after the 00 00 01 prefix
    localparam logic [7:0] ID_PACK  = 8'hba;
    localparam logic [7:0] ID_SYS   = 8'hbb;
    localparam logic [7:0] ID_MAP   = 8'hbc;
    localparam logic [7:0] ID_PRIV  = 8'hbd;
    localparam logic [7:0] ID_VIDEO = 8'he0;
    localparam logic [7:0] ID_AUDIO = 8'hc0;
    localparam logic [23:0] START_PREFIX = 24'h000001;

    // Header sizes
    localparam logic [15:0] PACK_FIX_LEN = 16'd10;
    localparam logic [15:0] PES_HDR_LEN  = 16'd5;
    localparam logic [15:0] LEN_FIELD    = 16'd2;
    localparam logic [2:0]  STUFF_MASK   = 3'h7;

    // Event codes
    localparam logic [1:0] EV_BYTE  = 2'd0;
    localparam logic [1:0] EV_LAST  = 2'd1;
    localparam logic [1:0] EV_ABORT = 2'd2;

    // Register indexes
    localparam logic REG_FWD_VIDEO = 1'b0;
    localparam logic REG_FWD_AUDIO = 1'b1;

    // Result queue
    localparam int QDEPTH = 8;
    localparam int QAW    = 3;
    localparam int MAXRES = 4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] event_res;
        logic       stream_kind;
    } t_res;

    typedef struct packed {
        logic [2:0]  cnt;
        t_res [3:0]  ent;
    } t_push;

endpackage

FILE: design/psd_front.sv
module psd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first,
    input  logic               i_last,
    input  logic               i_fwd_video,
    input  logic               i_fwd_audio,
    output psd_pkg::t_push     o_push
);

    logic [3:0]  r_phase, n_phase;
    logic [31:0] r_held, n_held;
    logic [2:0]  r_hcnt, n_hcnt;
    logic [15:0] r_skip, n_skip;
    logic [15:0] r_hf, n_hf;
    logic [15:0] r_fsize, n_fsize;
    logic [15:0] r_fcnt, n_fcnt;
    logic        r_cur, n_cur;
    logic        r_fopen, n_fopen;

    // One byte through the parser, plus replay of held start bytes
    always_comb begin : parse
        logic [3:0]  ph;
        logic [31:0] sh;
        logic        pre;
        logic [7:0]  id;
        logic        do_rep;
        logic [2:0]  rc;
        logic [31:0] rh;
        logic [15:0] rem;
        logic [15:0] remm1;
        logic [1:0]  bidx;
        logic        fwd;
        logic [2:0]  ne;
        n_phase = r_phase;
        n_held  = r_held;
        n_hcnt  = r_hcnt;
        n_skip  = r_skip;
        n_hf    = r_hf;
        n_fsize = r_fsize;
        n_fcnt  = r_fcnt;
        n_cur   = r_cur;
        n_fopen = r_fopen;
        do_rep  = 1'b0;
        rc      = 3'd0;
        rh      = 32'd0;
        rem     = 16'd0;
        remm1   = 16'd0;
        bidx    = 2'd0;
        ne      = 3'd0;
        sh      = 32'd0;
        pre     = 1'b0;
        id      = 8'd0;
        fwd     = r_cur ? i_fwd_audio : i_fwd_video;
        o_push  = '0;

        if (i_first) begin
            n_phase = psd_pkg::PH_START;
            n_held  = 32'd0;
            n_hcnt  = 3'd0;
        end
        ph = n_phase;

        case (ph)
            psd_pkg::PH_START, psd_pkg::PH_RESYNC, psd_pkg::PH_PESNEXT,
            psd_pkg::PH_PACK_NEXT, psd_pkg::PH_MAP_CODE: begin
                sh     = {n_held[23:0], i_data_byte};
                n_held = sh;
                n_hcnt = n_hcnt + 3'd1;
                if (n_hcnt == 3'd4) begin
                    n_hcnt = 3'd0;
                    pre    = (sh[31:8] == psd_pkg::START_PREFIX);
                    id     = sh[7:0];
                    if (ph == psd_pkg::PH_START) begin
                        if (pre && (id == psd_pkg::ID_PACK || id == psd_pkg::ID_VIDEO ||
                                    id == psd_pkg::ID_AUDIO)) begin
                            if (n_fopen) begin
                                o_push.ent[0].out_byte    = 8'd0;
                                o_push.ent[0].event_res   = psd_pkg::EV_ABORT;
                                o_push.ent[0].stream_kind = r_cur;
                                ne      = 3'd1;
                                n_fopen = 1'b0;
                                n_fcnt  = 16'd0;
                            end
                            if (id == psd_pkg::ID_PACK) begin
                                n_phase = psd_pkg::PH_PACK_FIX;
                                n_skip  = psd_pkg::PACK_FIX_LEN;
                            end else begin
                                n_cur   = (id == psd_pkg::ID_AUDIO);
                                n_phase = psd_pkg::PH_PES_HDR;
                                n_skip  = psd_pkg::PES_HDR_LEN;
                                n_hf    = 16'd0;
                            end
                        end else if (pre && id == psd_pkg::ID_PRIV) begin
                            n_phase = psd_pkg::PH_IDLE;
                        end else if (n_fopen) begin
                            n_phase = psd_pkg::PH_CONT;
                            do_rep  = 1'b1;
                            rc      = 3'd4;
                            rh      = sh;
                        end else begin
                            n_phase = psd_pkg::PH_IDLE;
                        end
                    end else if (pre && id == psd_pkg::ID_PACK && ph == psd_pkg::PH_RESYNC) begin
                        n_phase = psd_pkg::PH_PACK_FIX;
                        n_skip  = psd_pkg::PACK_FIX_LEN;
                    end else if (pre && (id == psd_pkg::ID_VIDEO || id == psd_pkg::ID_AUDIO) &&
                                 ph != psd_pkg::PH_MAP_CODE) begin
                        n_cur   = (id == psd_pkg::ID_AUDIO);
                        n_phase = psd_pkg::PH_PES_HDR;
                        n_skip  = psd_pkg::PES_HDR_LEN;
                        n_hf    = 16'd0;
                    end else if (pre && id == psd_pkg::ID_SYS &&
                                 ph == psd_pkg::PH_PACK_NEXT) begin
                        n_phase = psd_pkg::PH_SYS_LEN;
                        n_skip  = psd_pkg::LEN_FIELD;
                        n_hf    = 16'd0;
                    end else if (pre && id == psd_pkg::ID_MAP &&
                                 ph == psd_pkg::PH_MAP_CODE) begin
                        n_phase = psd_pkg::PH_MAP_LEN;
                        n_skip  = psd_pkg::LEN_FIELD;
                        n_hf    = 16'd0;
                    end else begin
                        n_phase = psd_pkg::PH_IDLE;
                    end
                end
            end
            psd_pkg::PH_PACK_FIX: begin
                n_skip = n_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    if ((i_data_byte[2:0] & psd_pkg::STUFF_MASK) != 3'd0) begin
                        n_skip  = {13'd0, i_data_byte[2:0]};
                        n_phase = psd_pkg::PH_PACK_STUFF;
                    end else begin
                        n_phase = psd_pkg::PH_PACK_NEXT;
                        n_held  = 32'd0;
                        n_hcnt  = 3'd0;
                    end
                end
            end
            psd_pkg::PH_PACK_STUFF: begin
                n_skip = n_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    n_phase = psd_pkg::PH_PACK_NEXT;
                    n_held  = 32'd0;
                    n_hcnt  = 3'd0;
                end
            end
            psd_pkg::PH_SYS_LEN, psd_pkg::PH_MAP_LEN: begin
                n_hf   = {n_hf[7:0], i_data_byte};
                n_skip = n_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    if (n_hf == 16'd0) begin
                        n_phase = (ph == psd_pkg::PH_SYS_LEN) ? psd_pkg::PH_MAP_CODE
                                                              : psd_pkg::PH_PESNEXT;
                        n_held  = 32'd0;
                        n_hcnt  = 3'd0;
                    end else begin
                        n_skip  = n_hf;
                        n_phase = ph + 4'd1;
                    end
                end
            end
            psd_pkg::PH_SYS_SKIP, psd_pkg::PH_MAP_SKIP: begin
                n_skip = n_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    n_phase = (ph == psd_pkg::PH_SYS_SKIP) ? psd_pkg::PH_MAP_CODE
                                                           : psd_pkg::PH_PESNEXT;
                    n_held  = 32'd0;
                    n_hcnt  = 3'd0;
                end
            end
            psd_pkg::PH_PES_HDR: begin
                n_skip = n_skip - 16'd1;
                if (n_skip == 16'd4) begin
                    n_hf = {i_data_byte, 8'd0};
                end else if (n_skip == 16'd3) begin
                    n_hf = {n_hf[15:8], i_data_byte};
                end else if (n_skip == 16'd0) begin
                    if ({1'b0, n_hf} < (17'd3 + {9'd0, i_data_byte})) begin
                        n_phase = psd_pkg::PH_IDLE;
                    end else begin
                        n_fsize = n_hf - 16'd3 - {8'd0, i_data_byte};
                        if (i_data_byte != 8'd0) begin
                            n_skip  = {8'd0, i_data_byte};
                            n_phase = psd_pkg::PH_PES_EXT;
                        end else begin
                            n_fcnt = 16'd0;
                            if (n_fsize == 16'd0) begin
                                n_fopen = 1'b0;
                                n_phase = psd_pkg::PH_PESNEXT;
                                n_held  = 32'd0;
                                n_hcnt  = 3'd0;
                            end else begin
                                n_fopen = 1'b1;
                                n_phase = psd_pkg::PH_BODY;
                            end
                        end
                    end
                end
            end
            psd_pkg::PH_PES_EXT: begin
                n_skip = n_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    n_fcnt = 16'd0;
                    if (n_fsize == 16'd0) begin
                        n_fopen = 1'b0;
                        n_phase = psd_pkg::PH_PESNEXT;
                        n_held  = 32'd0;
                        n_hcnt  = 3'd0;
                    end else begin
                        n_fopen = 1'b1;
                        n_phase = psd_pkg::PH_BODY;
                    end
                end
            end
            psd_pkg::PH_BODY, psd_pkg::PH_CONT: begin
                if (!n_fopen) begin
                    n_phase = psd_pkg::PH_IDLE;
                end else begin
                    n_fcnt = n_fcnt + 16'd1;
                    o_push.ent[0].out_byte    = i_data_byte;
                    o_push.ent[0].stream_kind = r_cur;
                    ne = 3'd1;
                    if (n_fcnt >= n_fsize) begin
                        o_push.ent[0].event_res = psd_pkg::EV_LAST;
                        n_fopen = 1'b0;
                        n_fcnt  = 16'd0;
                        n_phase = (ph == psd_pkg::PH_BODY) ? psd_pkg::PH_PESNEXT
                                                           : psd_pkg::PH_RESYNC;
                        n_held  = 32'd0;
                        n_hcnt  = 3'd0;
                    end else begin
                        o_push.ent[0].event_res = psd_pkg::EV_BYTE;
                    end
                end
            end
            default: begin
            end
        endcase

        // Packet ends with a partial start code inside an open frame
        if (i_last && n_phase == psd_pkg::PH_START && n_hcnt != 3'd0 && n_fopen) begin
            do_rep = 1'b1;
            rc     = n_hcnt;
            rh     = n_held;
        end

        // Replay held bytes as frame data; the frame may end partway
        if (do_rep) begin
            rem   = n_fsize - n_fcnt;
            remm1 = rem - 16'd1;
            for (int k = 0; k < psd_pkg::MAXRES; k++) begin
                if (3'(k) < rc && 16'(k) <= remm1) begin
                    bidx = 2'(rc - 3'd1 - 3'(k));
                    o_push.ent[k].out_byte    = rh[8*bidx +: 8];
                    o_push.ent[k].event_res   = (16'(k) == remm1) ? psd_pkg::EV_LAST
                                                                  : psd_pkg::EV_BYTE;
                    o_push.ent[k].stream_kind = r_cur;
                    ne = 3'(k + 1);
                end
            end
            if ({13'd0, rc} < rem) begin
                n_fcnt  = n_fcnt + {13'd0, rc};
                n_phase = psd_pkg::PH_CONT;
                n_hcnt  = 3'd0;
            end else begin
                n_fopen = 1'b0;
                n_fcnt  = 16'd0;
                n_phase = psd_pkg::PH_RESYNC;
                n_hcnt  = rc - rem[2:0];
                n_held  = rh;
            end
        end

        if (i_last) begin
            n_phase = psd_pkg::PH_IDLE;
            n_hcnt  = 3'd0;
        end

        o_push.cnt = (i_accept && fwd) ? ne : 3'd0;
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= psd_pkg::PH_IDLE;
            r_held  <= 32'd0;
            r_hcnt  <= 3'd0;
            r_skip  <= 16'd0;
            r_hf    <= 16'd0;
            r_fsize <= 16'd0;
            r_fcnt  <= 16'd0;
            r_cur   <= 1'b0;
            r_fopen <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_hcnt  <= n_hcnt;
            r_skip  <= n_skip;
            r_hf    <= n_hf;
            r_fsize <= n_fsize;
            r_fcnt  <= n_fcnt;
            r_cur   <= n_cur;
            r_fopen <= n_fopen;
        end
    end

endmodule

FILE: design/psd_queue.sv
module psd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  psd_pkg::t_push  i_push,
    output logic            o_room,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,
    output logic [2:0]      o_m_tuser
);

    psd_pkg::t_res [psd_pkg::QDEPTH-1:0] r_mem;
    logic [psd_pkg::QAW-1:0] r_wr, r_rd;
    logic [psd_pkg::QAW:0]   r_cnt, n_cnt;
    logic                    pop;

    assign pop        = o_m_tvalid && i_m_tready;
    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tdata  = r_mem[r_rd].out_byte;
    assign o_m_tuser  = {r_mem[r_rd].stream_kind, r_mem[r_rd].event_res};
    // Front may step only if a full burst of results fits
    assign o_room     = (r_cnt <= (psd_pkg::QAW+1)'(psd_pkg::QDEPTH - psd_pkg::MAXRES));
    assign n_cnt      = r_cnt + (psd_pkg::QAW+1)'(i_push.cnt) - {{psd_pkg::QAW{1'b0}}, pop};

    // Burst write of up to four results
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < psd_pkg::MAXRES; k++) begin
            if (3'(k) < i_push.cnt) begin
                r_mem[r_wr + psd_pkg::QAW'(k)] <= i_push.ent[k];
            end
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + psd_pkg::QAW'(i_push.cnt);
            r_rd  <= r_rd + psd_pkg::QAW'(pop);
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: design/program_stream_pes_demux.sv
// Result beats are written to the result queue as their input beat is accepted.
// Throughput: one input beat per cycle; the front stalls while the 8-entry result
// queue holds more than 4 beats; it drains a beat per cycle if i_m_tready is high.
// An input beat can cause up to 4 result beats (replayed start-code bytes).
// Reset (i_rst_n low, synchronous) idles the parser, empties the queue and sets
// forward_video = 1, forward_audio = 0.
module program_stream_pes_demux (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] first_of_packet
    input  logic        i_s_tlast,   // last_of_packet
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic [2:0]  o_m_tuser,   // [1:0] event_res, [2] stream_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic           r_fwd_video;
    logic           r_fwd_audio;
    logic           accept;
    logic           room;
    psd_pkg::t_push push;

    assign pready     = 1'b1;
    assign o_s_tready = room;
    assign accept     = i_s_tvalid && room;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_video <= 1'b1;
            r_fwd_audio <= 1'b0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == psd_pkg::REG_FWD_VIDEO) r_fwd_video <= pwdata[0];
            if (paddr[2] == psd_pkg::REG_FWD_AUDIO) r_fwd_audio <= pwdata[0];
        end
    end

    assign prdata = {31'd0, (paddr[2] == psd_pkg::REG_FWD_AUDIO) ? r_fwd_audio : r_fwd_video};

    psd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_s_tdata),
        .i_first     (i_s_tuser),
        .i_last      (i_s_tlast),
        .i_fwd_video (r_fwd_video),
        .i_fwd_audio (r_fwd_audio),
        .o_push      (push)
    );

    psd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_room     (room),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
